>>> src/nibble_playfair_cbc_cipher_defines.svh
// Assertion macros shared by the nibble Playfair CBC cipher RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef NIBBLE_PLAYFAIR_CBC_CIPHER_DEFINES_SVH
`define NIBBLE_PLAYFAIR_CBC_CIPHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npc assertion failed");

// Next-cycle implication, checked out of reset.
`define NPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npc assertion failed");

`endif

>>> src/npc_pkg.sv
// Package for the nibble Playfair CBC cipher: types, constants, cipher functions.
// Used by every module of the block; depends on nothing.
package npc_pkg;

  localparam int NPC_BLOCK_BYTES = 4;
  localparam int NPC_POS_W       = $clog2(NPC_BLOCK_BYTES);
  localparam int NPC_QUEUE_DEPTH = 2;

  localparam logic [63:0] NPC_KEY_RESET = 64'hFEDC_BA98_7654_3210;
  localparam logic [31:0] NPC_IV_RESET  = 32'h6AA2_9EBE;

  typedef enum logic [1:0] {
    CFG_KEY_SQUARE  = 2'd0,
    CFG_DIRECTION   = 2'd1,
    CFG_CHAINING    = 2'd2,
    CFG_INIT_VECTOR = 2'd3
  } npc_cfg_idx_t;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 chain_en;
    logic                 load_iv;
    logic [NPC_POS_W-1:0] pos;
  } npc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } npc_q_stat_t;

  function automatic logic [3:0] key_entry(input logic [63:0] key, input logic [3:0] idx);
    return key[{idx, 2'b00} +: 4];
  endfunction

  // Lowest matching entry wins; a nibble found nowhere maps to entry 0.
  function automatic logic [3:0] locate(input logic [63:0] key, input logic [3:0] nib);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (key[4*i +: 4] == nib) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [7:0] playfair(input logic [63:0] key, input logic [7:0] din,
                                          input logic dec);
    logic [3:0] ak;
    logic [3:0] bk;
    logic [1:0] ar;
    logic [1:0] ac;
    logic [1:0] br;
    logic [1:0] bc;
    logic [1:0] step;
    logic [3:0] hi;
    logic [3:0] lo;
    ak   = locate(key, din[7:4]);
    bk   = locate(key, din[3:0]);
    ar   = ak[3:2];
    ac   = ak[1:0];
    br   = bk[3:2];
    bc   = bk[1:0];
    step = dec ? 2'd3 : 2'd1;
    if (ar == br) begin
      hi = key_entry(key, {ar, 2'(ac + step)});
      lo = key_entry(key, {br, 2'(bc + step)});
    end else if (ac == bc) begin
      hi = key_entry(key, {2'(ar + step), ac});
      lo = key_entry(key, {2'(br + step), bc});
    end else begin
      hi = key_entry(key, {ar, bc});
      lo = key_entry(key, {br, ac});
    end
    return {hi, lo};
  endfunction

endpackage

>>> src/npc_front.sv
// Front end: accepts input bytes and tags each with its chain position.
// Depends on npc_pkg.
module npc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               chaining,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  npc_pkg::npc_q_stat_t q_stat,
  output logic               push,
  output npc_pkg::npc_item_t push_item,
  output logic               fresh
);
  import npc_pkg::*;

  logic [NPC_POS_W-1:0] pos_r, pos_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [NPC_POS_W-1:0] cur_pos;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign fresh    = fresh_r;

  always_comb begin
    cur_pos             = fresh_r ? '0 : pos_r;
    push_item.data      = in_data_byte;
    push_item.last      = in_last_byte;
    push_item.chain_en  = chaining;
    push_item.load_iv   = fresh_r;
    push_item.pos       = cur_pos;
  end

  always_comb begin
    pos_nxt   = pos_r;
    fresh_nxt = fresh_r;
    if (push) begin
      if (chaining) begin
        pos_nxt   = NPC_POS_W'(cur_pos + 1'b1);
        fresh_nxt = 1'b0;
      end
      // a last byte restarts the chain
      if (in_last_byte) begin
        pos_nxt   = '0;
        fresh_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fresh_r <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      fresh_r <= fresh_nxt;
    end
  end

endmodule

>>> src/npc_queue.sv
// Small FIFO decoupling the front end from the cipher back end.
// Depends on npc_pkg; DEPTH must be 2 or more.
module npc_queue #(
  parameter int DEPTH = npc_pkg::NPC_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  npc_pkg::npc_item_t   push_item,
  input  logic                 pop,
  output npc_pkg::npc_item_t   head_item,
  output npc_pkg::npc_q_stat_t stat
);
  import npc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  npc_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_item  = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/npc_back.sv
// Back end: chain XOR, Playfair substitution, chain update and output register.
// Depends on npc_pkg.
module npc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        key_square,
  input  logic               direction,
  input  logic [31:0]        init_vector,
  input  logic               q_valid,
  input  npc_pkg::npc_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_result_byte,
  output logic               out_end_mark
);
  import npc_pkg::*;

  logic [31:0]          chain_r, chain_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           result_r;
  logic                 end_r;
  logic [31:0]          cb;
  logic [NPC_POS_W-1:0] sel;
  logic [7:0]           prev;
  logic [7:0]           res;

  assign pop             = q_valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_result_byte = result_r;
  assign out_end_mark    = end_r;

  always_comb begin
    cb        = q_item.load_iv ? init_vector : chain_r;
    // first byte of a block sits in the top byte lane
    sel       = NPC_POS_W'(NPC_BLOCK_BYTES - 1) - q_item.pos;
    prev      = cb[{sel, 3'b000} +: 8];
    chain_nxt = chain_r;
    if (!q_item.chain_en) begin
      res = playfair(key_square, q_item.data, direction);
    end else if (direction) begin
      res = playfair(key_square, q_item.data, 1'b1) ^ prev;
    end else begin
      res = playfair(key_square, q_item.data ^ prev, 1'b0);
    end
    if (pop && q_item.chain_en) begin
      chain_nxt                  = cb;
      chain_nxt[{sel, 3'b000} +: 8] = direction ? q_item.data : res;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= res;
      end_r    <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/nibble_playfair_cbc_cipher.sv
// Top level of the nibble Playfair cipher with optional CBC chaining.
// Depends on npc_pkg, npc_front, npc_queue, npc_back and the defines header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready  | in_data_byte, in_last_byte
//   out     | output    | out_valid / out_ready| out_result_byte, out_end_mark
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready stays high; a byte is written to the
// queue at its transfer edge and ciphered into the output register when the back
// end pops it, which a stalled output can delay.
// Reset clears the queue, the chain state and the output valid; config
// registers return to their defaults. A stalled output holds its byte while
// the queue keeps taking bytes until it fills, then in_ready drops.
module nibble_playfair_cbc_cipher #(
  parameter int QUEUE_DEPTH = npc_pkg::NPC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_result_byte,
  output logic        out_end_mark,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import npc_pkg::*;

`include "nibble_playfair_cbc_cipher_defines.svh"

  logic [63:0] key_r;
  logic        dir_r;
  logic        chain_r;
  logic [31:0] iv_r;

  npc_item_t   push_item;
  npc_item_t   head_item;
  npc_q_stat_t q_stat;
  logic        push;
  logic        pop;
  logic        fresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= NPC_KEY_RESET;
      dir_r   <= 1'b0;
      chain_r <= 1'b0;
      iv_r    <= NPC_IV_RESET;
    end else if (cfg_we) begin
      unique case (npc_cfg_idx_t'(cfg_index))
        CFG_KEY_SQUARE:  key_r   <= cfg_data;
        CFG_DIRECTION:   dir_r   <= cfg_data[0];
        CFG_CHAINING:    chain_r <= cfg_data[0];
        CFG_INIT_VECTOR: iv_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  npc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .chaining     (chain_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item),
    .fresh        (fresh)
  );

  npc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  npc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_square      (key_r),
    .direction       (dir_r),
    .init_vector     (iv_r),
    .q_valid         (!q_stat.empty),
    .q_item          (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_byte (out_result_byte),
    .out_end_mark    (out_end_mark)
  );

  `NPC_ASSERT_NEXT(a_push_fills_queue, push, !q_stat.empty)
  `NPC_ASSERT_NEXT(a_pop_loads_output, pop, out_valid)
  `NPC_ASSERT_NEXT(a_last_marks_output, pop && head_item.last, out_valid && out_end_mark)
  `NPC_ASSERT_NEXT(a_last_restarts_chain, push && in_last_byte, fresh)

endmodule

>>> tb/npc_cipher_checker.sv
// Checker for the nibble Playfair CBC cipher: watches the config port and both
// channels, predicts every result byte and compares it. Depends on npc_pkg.
module npc_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_result_byte,
  input  logic        out_end_mark,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          pending_results,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import npc_pkg::*;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       end_mark;
  } cipher_out_t;

  cipher_out_t expected_q[$];

  // Own copy of the registers and the chain
  logic [63:0] key_sq;
  logic        decrypting;
  logic        chained;
  logic [31:0] iv_word;
  logic [31:0] chain_word;
  logic [1:0]  block_slot;
  logic        restart_chain;

  initial begin
    mismatches      = 0;
    pending_results = 0;
    results_checked = 0;
  end

  // First cell of the square holding the nibble; cell 0 when it is absent.
  function automatic logic [3:0] find_cell(input logic [63:0] sq, input logic [3:0] nib);
    for (int i = 0; i < 16; i++) begin
      if (sq[4*i +: 4] == nib) return 4'(i);
    end
    return 4'd0;
  endfunction

  function automatic logic [7:0] cipher_byte(input logic [63:0] sq, input logic [7:0] val,
                                             input logic dec);
    logic [3:0] pos_hi;
    logic [3:0] pos_lo;
    logic [3:0] new_hi;
    logic [3:0] new_lo;
    logic [1:0] move;
    pos_hi = find_cell(sq, val[7:4]);
    pos_lo = find_cell(sq, val[3:0]);
    move   = dec ? 2'd3 : 2'd1;
    // Row and column fields wrap at 2 bits inside the concatenations.
    if (pos_hi[3:2] == pos_lo[3:2]) begin
      new_hi = {pos_hi[3:2], pos_hi[1:0] + move};
      new_lo = {pos_lo[3:2], pos_lo[1:0] + move};
    end else if (pos_hi[1:0] == pos_lo[1:0]) begin
      new_hi = {pos_hi[3:2] + move, pos_hi[1:0]};
      new_lo = {pos_lo[3:2] + move, pos_lo[1:0]};
    end else begin
      new_hi = {pos_hi[3:2], pos_lo[1:0]};
      new_lo = {pos_lo[3:2], pos_hi[1:0]};
    end
    return {sq[4*new_hi +: 4], sq[4*new_lo +: 4]};
  endfunction

  always @(posedge clk) begin : monitor
    cipher_out_t got;
    cipher_out_t want;
    logic [7:0]  res;
    logic [7:0]  prev;
    int          sh;
    if (!rst_n) begin
      key_sq        = NPC_KEY_RESET;
      decrypting    = 1'b0;
      chained       = 1'b0;
      iv_word       = NPC_IV_RESET;
      chain_word    = '0;
      block_slot    = '0;
      restart_chain = 1'b1;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_SQUARE:  key_sq     = cfg_data;
          CFG_DIRECTION:   decrypting = cfg_data[0];
          CFG_CHAINING:    chained    = cfg_data[0];
          CFG_INIT_VECTOR: iv_word    = cfg_data[31:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (chained) begin
          if (restart_chain) begin
            chain_word    = iv_word;
            block_slot    = '0;
            restart_chain = 1'b0;
          end
          // first byte of a block sits in the top byte of the chain word
          sh   = 8 * (3 - int'(block_slot));
          prev = chain_word[sh +: 8];
          if (decrypting) begin
            res = cipher_byte(key_sq, in_data_byte, 1'b1) ^ prev;
            chain_word[sh +: 8] = in_data_byte;
          end else begin
            res = cipher_byte(key_sq, in_data_byte ^ prev, 1'b0);
            chain_word[sh +: 8] = res;
          end
          block_slot = block_slot + 2'd1;
        end else begin
          res = cipher_byte(key_sq, in_data_byte, decrypting);
        end
        if (in_last_byte) begin
          restart_chain = 1'b1;
          block_slot    = '0;
        end
        expected_q.push_back({res, in_last_byte});
      end

      if (out_valid && out_ready) begin
        got = {out_result_byte, out_end_mark};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %h end %b", got.result_byte, got.end_mark);
        end else begin
          want = expected_q.pop_front();
          if (got.result_byte !== want.result_byte || got.end_mark !== want.end_mark) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected byte %h end %b, got byte %h end %b",
                       results_checked, want.result_byte, want.end_mark,
                       got.result_byte, got.end_mark);
          end
        end
        results_checked++;
      end
      pending_results = expected_q.size();
    end
  end

endmodule

>>> tb/nibble_playfair_cbc_cipher_test.sv
// Top of the nibble Playfair CBC cipher testbench: clock, reset, byte stream,
// register settings and verdict. Depends on npc_pkg, nibble_playfair_cbc_cipher and npc_cipher_checker.
module nibble_playfair_cbc_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import npc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 120;
  localparam int PHASES       = 12;
  localparam int PHASE_BYTES  = 75;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_result_byte;
  logic        out_end_mark;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int   mismatches;
  int   pending_results;
  int   results_checked;
  int   bytes_sent = 0;
  int   settings   = 1;
  int   cycle_count = 0;
  logic steady;
  logic hold_req;

  nibble_playfair_cbc_cipher uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_byte (out_result_byte),
    .out_end_mark    (out_end_mark),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  npc_cipher_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_byte (out_result_byte),
    .out_end_mark    (out_end_mark),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results);
      $display("nibble_playfair_cbc_cipher_test NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none in steady stretches.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic int msg_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(1, 4);
    if (r < 9) return $urandom_range(5, 16);
    return $urandom_range(17, 40);
  endfunction

  function automatic logic [63:0] shuffled_square();
    logic [3:0]  cells[16];
    logic [3:0]  tmp;
    logic [63:0] sq;
    int          j;
    for (int i = 0; i < 16; i++) cells[i] = 4'(i);
    for (int i = 15; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = cells[i];
      cells[i] = cells[j];
      cells[j] = tmp;
    end
    for (int i = 0; i < 16; i++) sq[4*i +: 4] = cells[i];
    return sq;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] val, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= val;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic [7:0] vals[$]);
    foreach (vals[i]) send_byte(vals[i], i == vals.size() - 1);
  endtask

  // Drop valid and hold until every predicted byte has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic [63:0] key, input logic dec, input logic chain,
                              input logic [31:0] iv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_SQUARE;
    cfg_data  <= key;
    @(negedge clk);
    cfg_index <= CFG_DIRECTION;
    cfg_data  <= {63'd0, dec};
    @(negedge clk);
    cfg_index <= CFG_CHAINING;
    cfg_data  <= {63'd0, chain};
    @(negedge clk);
    cfg_index <= CFG_INIT_VECTOR;
    cfg_data  <= {32'd0, iv};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  msg[$];
    logic [63:0] key;
    logic [31:0] iv;
    int          left;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_KEY_SQUARE;
    cfg_data     = '0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    left         = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: identity square, encrypt, plain. Equal nibbles, row, column,
    // wrap in both and the rectangle case.
    msg = {8'h00, 8'hFF, 8'h0F, 8'h05, 8'h04, 8'h03, 8'hC0, 8'h3C, 8'hA5};
    send_run(msg);
    wait_idle();
    program_regs(NPC_KEY_RESET, 1'b1, 1'b0, NPC_IV_RESET);
    settings++;
    msg = {8'h00, 8'h0F, 8'h04, 8'hC0, 8'h5A};
    send_run(msg);
    // Chained message ending in a partial block
    wait_idle();
    program_regs(NPC_KEY_RESET, 1'b0, 1'b1, NPC_IV_RESET);
    settings++;
    msg = {8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
    send_run(msg);
    // Square with repeats and missing nibbles
    wait_idle();
    program_regs(64'h0000_0000_0000_3A3A, 1'b0, 1'b0, NPC_IV_RESET);
    settings++;
    msg = {8'h3A, 8'h77, 8'hA3};
    send_run(msg);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 6)
        2:       key = {$urandom, $urandom};
        4:       key = (ph < 6) ? 64'd0 : '1;
        5:       key = NPC_KEY_RESET;
        default: key = shuffled_square();
      endcase
      if (ph % 5 == 0)      iv = '0;
      else if (ph % 5 == 1) iv = '1;
      else                  iv = $urandom;
      program_regs(key, 1'(ph % 2), ph % 4 != 1, iv);
      settings++;
      steady   = (ph % 4 == 3);
      hold_req = (ph == 2);
      // Messages run across phase ends, so settings also change mid-message.
      for (int k = 0; k < PHASE_BYTES; k++) begin
        if (left == 0) left = msg_len();
        left--;
        send_byte(8'($urandom_range(0, 255)), left == 0);
      end
    end

    steady = 1'b0;
    wait_idle();
    repeat (8) @(negedge clk);
    $display("covered %0d bytes over %0d register settings: both directions, plain and chained",
             bytes_sent, settings);
    $display("%0d results checked, %0d failures, %0d outstanding",
             results_checked, mismatches, pending_results);
    if (mismatches == 0 && pending_results == 0) begin
      $display("nibble_playfair_cbc_cipher_test OK");
    end else begin
      $display("nibble_playfair_cbc_cipher_test NOT OK");
    end
    $finish;
  end

endmodule

>>> nibble_playfair_cbc_cipher.f
+incdir+src
src/npc_pkg.sv
src/npc_front.sv
src/npc_queue.sv
src/npc_back.sv
src/nibble_playfair_cbc_cipher.sv
tb/npc_cipher_checker.sv
tb/nibble_playfair_cbc_cipher_test.sv
